// File: sv/smee_pkg.sv
// ----------------------------------------------------------------------------
// Sensor to MIDI event encoder package
// Shared types, register indexes, reset values and MIDI constants.
// ----------------------------------------------------------------------------
package smee_pkg;

    // Widest sensor channel count the block supports.
    localparam int MAX_CH = 8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_VELOCITY  = 3'd1;
    localparam logic [2:0] CFG_NOTE_CH0  = 3'd2;
    localparam logic [2:0] CFG_NOTE_CH1  = 3'd3;
    localparam logic [2:0] CFG_NOTE_CH2  = 3'd4;
    localparam logic [2:0] CFG_PROGRAM_A = 3'd5;
    localparam logic [2:0] CFG_PROGRAM_B = 3'd6;
    localparam logic [2:0] CFG_PROGRAM_C = 3'd7;

    // Register reset values.
    localparam logic [9:0] RST_THRESHOLD = 10'd200;
    localparam logic [6:0] RST_VELOCITY  = 7'h40;
    localparam logic [6:0] RST_NOTE_CH0  = 7'd87;
    localparam logic [6:0] RST_NOTE_CH1  = 7'd69;
    localparam logic [6:0] RST_NOTE_CH2  = 7'd51;
    localparam logic [6:0] RST_PROGRAM_A = 7'h01;
    localparam logic [6:0] RST_PROGRAM_B = 7'h41;
    localparam logic [6:0] RST_PROGRAM_C = 7'h19;

    // MIDI constants.
    localparam logic [7:0] NOTE_ON_STATUS  = 8'h90;
    localparam logic [7:0] PROGRAM_STATUS  = 8'hC0;
    localparam logic [6:0] DEFAULT_NOTE    = 7'd60;
    localparam logic [6:0] NOTE_OFF_VEL    = 7'h00;

    // Conversion phase at which a sample is taken, and instrument count limit.
    localparam logic [1:0] SAMPLE_PHASE    = 2'd2;
    localparam logic [1:0] LAST_INSTRUMENT = 2'd2;

    // Program change messages go to MIDI channels 0 .. 2.
    localparam logic [1:0] LAST_PROG_CH    = 2'd2;

    // Byte positions inside a message.
    localparam logic [1:0] BYTE_STATUS = 2'd0;
    localparam logic [1:0] BYTE_DATA1  = 2'd1;
    localparam logic [1:0] BYTE_DATA2  = 2'd2;

    typedef struct packed {
        logic [9:0] threshold;
        logic [6:0] velocity;
        logic [6:0] note_ch0;
        logic [6:0] note_ch1;
        logic [6:0] note_ch2;
        logic [6:0] program_a;
        logic [6:0] program_b;
        logic [6:0] program_c;
    } t_cfg;

    // Work handed from the tracker to the byte sequencer for one tick.
    typedef struct packed {
        logic              load;
        logic [MAX_CH-1:0] changed;
        logic [MAX_CH-1:0] level;
        logic              prog;
        logic [6:0]        prog_num;
    } t_job;

endpackage

// File: sv/smee_track.sv
// ----------------------------------------------------------------------------
// Sensor to MIDI event encoder: input register and sensor state
// Registers each item, samples beam levels and builds the message job of a tick.
// ----------------------------------------------------------------------------
module smee_track #(
    parameter int SENSOR_CHANNELS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_req_type,
    input  logic [9:0]    i_adc_value,
    input  logic          i_button_level,
    input  smee_pkg::t_cfg i_cfg,
    output smee_pkg::t_job o_job,
    output logic          o_tick_pending
);
    import smee_pkg::*;

    localparam int CH_W = (SENSOR_CHANNELS > 1) ? $clog2(SENSOR_CHANNELS) : 1;

    logic                       r_in_valid;
    logic                       r_in_req;
    logic [9:0]                 r_in_adc;
    logic                       r_in_btn;
    logic [1:0]                 r_conv_phase;
    logic [CH_W-1:0]            r_sample_ch;
    logic [SENSOR_CHANNELS-1:0] r_hand_present;
    logic [SENSOR_CHANNELS-1:0] r_hand_before;
    logic [1:0]                 r_instr_idx;
    logic                       r_button_before;

    logic            conv;
    logic            tick;
    logic            press;
    logic            above;
    logic [1:0]      n_conv_phase;
    logic [CH_W-1:0] n_sample_ch;
    logic [1:0]      n_instr_idx;
    logic [6:0]      prog_num;

    assign conv  = r_in_valid & ~r_in_req;
    assign tick  = r_in_valid & r_in_req;
    assign press = tick & ~r_in_btn & r_button_before;
    assign above = (r_in_adc > i_cfg.threshold);

    assign n_conv_phase = (r_conv_phase == SAMPLE_PHASE) ? 2'd0 : r_conv_phase + 2'd1;
    assign n_sample_ch  = (r_sample_ch == CH_W'(SENSOR_CHANNELS - 1)) ?
                          '0 : r_sample_ch + CH_W'(1);
    assign n_instr_idx  = (r_instr_idx == LAST_INSTRUMENT) ? 2'd0 : r_instr_idx + 2'd1;

    always_comb begin
        unique case (n_instr_idx)
            2'd1:    prog_num = i_cfg.program_b;
            2'd2:    prog_num = i_cfg.program_c;
            default: prog_num = i_cfg.program_a;
        endcase
    end

    always_comb begin
        o_job.load     = tick;
        o_job.changed  = MAX_CH'(r_hand_present ^ r_hand_before);
        o_job.level    = MAX_CH'(r_hand_present);
        o_job.prog     = press;
        o_job.prog_num = prog_num;
    end

    assign o_tick_pending = tick;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_req <= i_req_type;
            r_in_adc <= i_adc_value;
            r_in_btn <= i_button_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_conv_phase    <= 2'd0;
            r_sample_ch     <= '0;
            r_hand_present  <= '0;
            r_hand_before   <= '0;
            r_instr_idx     <= 2'd0;
            r_button_before <= 1'b1;
        end else begin
            r_in_valid <= i_accept;
            if (conv) begin
                r_conv_phase <= n_conv_phase;
                if (n_conv_phase == SAMPLE_PHASE) begin
                    for (int i = 0; i < SENSOR_CHANNELS; i++) begin
                        if (r_sample_ch == CH_W'(i)) begin
                            r_hand_present[i] <= above;
                        end
                    end
                    r_sample_ch <= n_sample_ch;
                end
            end
            if (tick) begin
                r_hand_before   <= r_hand_present;
                r_button_before <= r_in_btn;
                if (press) begin
                    r_instr_idx <= n_instr_idx;
                end
            end
        end
    end

endmodule

// File: sv/smee_emit.sv
// ----------------------------------------------------------------------------
// Sensor to MIDI event encoder: byte sequencer
// Sends one tick's messages a byte per cycle, unless stalled, via an output register.
// ----------------------------------------------------------------------------
module smee_emit #(
    parameter int SENSOR_CHANNELS = 3
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smee_pkg::t_job i_job,
    input  smee_pkg::t_cfg i_cfg,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_midi_byte,
    output logic           o_last_byte,
    output logic           o_busy
);
    import smee_pkg::*;

    logic [SENSOR_CHANNELS-1:0] r_pend;
    logic [SENSOR_CHANNELS-1:0] r_level;
    logic                       r_prog;
    logic [6:0]                 r_prog_num;
    logic [1:0]                 r_sub;
    logic [1:0]                 r_pk;
    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_last;

    logic [SENSOR_CHANNELS-1:0] cur_onehot;
    logic [SENSOR_CHANNELS-1:0] rest;
    logic [2:0]                 cur_ch;
    logic                       cur_level;
    logic [6:0]                 cur_note;
    logic                       in_notes;
    logic                       advance;
    logic [7:0]                 n_byte;
    logic                       n_last;

    // Lowest channel still waiting for its message.
    assign cur_onehot = r_pend & (~r_pend + SENSOR_CHANNELS'(1));
    assign rest       = r_pend & ~cur_onehot;
    assign in_notes   = |r_pend;
    assign o_busy     = in_notes | r_prog;
    assign advance    = o_busy & (~r_out_valid | ~i_stall);

    always_comb begin
        cur_ch    = 3'd0;
        cur_level = 1'b0;
        for (int i = 0; i < SENSOR_CHANNELS; i++) begin
            if (cur_onehot[i]) begin
                cur_ch    = cur_ch | 3'(i);
                cur_level = r_level[i];
            end
        end
    end

    always_comb begin
        unique case (cur_ch)
            3'd0:    cur_note = i_cfg.note_ch0;
            3'd1:    cur_note = i_cfg.note_ch1;
            3'd2:    cur_note = i_cfg.note_ch2;
            default: cur_note = DEFAULT_NOTE;
        endcase
    end

    always_comb begin
        n_byte = 8'h00;
        n_last = 1'b0;
        if (in_notes) begin
            unique case (r_sub)
                BYTE_STATUS: n_byte = NOTE_ON_STATUS | {5'b0, cur_ch};
                BYTE_DATA1:  n_byte = {1'b0, cur_note};
                default:     n_byte = {1'b0, cur_level ? i_cfg.velocity : NOTE_OFF_VEL};
            endcase
            n_last = (r_sub == BYTE_DATA2) && (rest == '0) && !r_prog;
        end else begin
            if (r_sub == BYTE_STATUS) begin
                n_byte = PROGRAM_STATUS | {6'b0, r_pk};
            end else begin
                n_byte = {1'b0, r_prog_num};
            end
            n_last = (r_pk == LAST_PROG_CH) && (r_sub == BYTE_DATA1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.load) begin
            r_level    <= i_job.level[SENSOR_CHANNELS-1:0];
            r_prog_num <= i_job.prog_num;
        end
        if (advance) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_prog      <= 1'b0;
            r_sub       <= BYTE_STATUS;
            r_pk        <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_job.load) begin
                r_pend <= i_job.changed[SENSOR_CHANNELS-1:0];
                r_prog <= i_job.prog;
                r_sub  <= BYTE_STATUS;
                r_pk   <= 2'd0;
            end else if (advance) begin
                if (in_notes) begin
                    if (r_sub == BYTE_DATA2) begin
                        r_sub  <= BYTE_STATUS;
                        r_pend <= rest;
                    end else begin
                        r_sub <= r_sub + 2'd1;
                    end
                end else begin
                    if (r_sub == BYTE_DATA1) begin
                        r_sub <= BYTE_STATUS;
                        if (r_pk == LAST_PROG_CH) begin
                            r_prog <= 1'b0;
                            r_pk   <= 2'd0;
                        end else begin
                            r_pk <= r_pk + 2'd1;
                        end
                    end else begin
                        r_sub <= BYTE_DATA1;
                    end
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_midi_byte = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

// File: sv/sensor_to_midi_event_encoder_top.sv
// ----------------------------------------------------------------------------
// Sensor to MIDI event encoder
// Turns beam sensor conversions and timer ticks into a stream of MIDI bytes.
// ----------------------------------------------------------------------------
// A conversion item produces no bytes; every third conversion samples the
// current sensor channel against the threshold and moves on to the next
// channel. A tick item produces three bytes of note-on (velocity zero for a
// released beam) for each channel whose hand flag changed, followed by six
// bytes of program change on MIDI channels 0 to 2 when the button went from
// released to pressed, so at most 3*SENSOR_CHANNELS+6 bytes. Items pass
// through an input register, and a tick is handed to the byte sequencer,
// which sends one byte per cycle into the output register while the output
// is not stalled; a tick goes from the input register into the sequencer,
// and its first byte then into the output register. Conversions are accepted
// every cycle, also while a tick is being sent. A further tick is held off
// (stall high) while the previous tick is in the input register or the
// sequencer still has bytes to send. Stall on the output side only pauses
// the sequencer. The last byte of each tick carries o_last_byte. Configuration
// writes are always accepted and should be made while no item is in flight.
// ----------------------------------------------------------------------------
module sensor_to_midi_event_encoder_top #(
    parameter int SENSOR_CHANNELS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_req_type,
    input  logic [9:0] i_adc_value,
    input  logic       i_button_level,
    // Byte output channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_midi_byte,
    output logic       o_last_byte,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    import smee_pkg::*;

    t_cfg r_cfg;
    t_job job;
    logic tick_pending;
    logic emit_busy;
    logic accept;

    // Only ticks wait for the sequencer; conversions always pass.
    assign o_stall     = i_req_type & (tick_pending | emit_busy);
    assign accept      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; values are masked to their register widths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.velocity  <= RST_VELOCITY;
            r_cfg.note_ch0  <= RST_NOTE_CH0;
            r_cfg.note_ch1  <= RST_NOTE_CH1;
            r_cfg.note_ch2  <= RST_NOTE_CH2;
            r_cfg.program_a <= RST_PROGRAM_A;
            r_cfg.program_b <= RST_PROGRAM_B;
            r_cfg.program_c <= RST_PROGRAM_C;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data;
                CFG_VELOCITY:  r_cfg.velocity  <= i_cfg_data[6:0];
                CFG_NOTE_CH0:  r_cfg.note_ch0  <= i_cfg_data[6:0];
                CFG_NOTE_CH1:  r_cfg.note_ch1  <= i_cfg_data[6:0];
                CFG_NOTE_CH2:  r_cfg.note_ch2  <= i_cfg_data[6:0];
                CFG_PROGRAM_A: r_cfg.program_a <= i_cfg_data[6:0];
                CFG_PROGRAM_B: r_cfg.program_b <= i_cfg_data[6:0];
                CFG_PROGRAM_C: r_cfg.program_c <= i_cfg_data[6:0];
            endcase
        end
    end

    smee_track #(
        .SENSOR_CHANNELS(SENSOR_CHANNELS)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req_type),
        .i_adc_value    (i_adc_value),
        .i_button_level (i_button_level),
        .i_cfg          (r_cfg),
        .o_job          (job),
        .o_tick_pending (tick_pending)
    );

    smee_emit #(
        .SENSOR_CHANNELS(SENSOR_CHANNELS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_cfg       (r_cfg),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_midi_byte (o_midi_byte),
        .o_last_byte (o_last_byte),
        .o_busy      (emit_busy)
    );

    // A new tick job must never land on a sequencer that is still sending.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job.load |-> !emit_busy)
        else $error("tick job loaded while sequencer busy");

    // The sequencer only becomes busy because a job was loaded.
    a_busy_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(emit_busy) |-> $past(job.load))
        else $error("sequencer busy without a job");

    // With bytes to send and an empty output register, a byte follows next cycle.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_busy && !o_valid) |=> o_valid)
        else $error("sequencer left the output register empty");

    // An accepted tick always finds the sequencer free.
    a_tick_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type) |-> (!emit_busy && !tick_pending))
        else $error("tick accepted while another tick was in flight");

endmodule
